// ===== design/token_scanner_core_macros.svh =====
// ----------------------------------------------------------------------------
// token_scanner_core_macros
// Assertion macros used by the token scanner RTL.
// ----------------------------------------------------------------------------
`ifndef TOKEN_SCANNER_CORE_MACROS_SVH
`define TOKEN_SCANNER_CORE_MACROS_SVH

// check a condition in the same cycle, outside reset
`define TSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("token scanner check failed");

// check a condition in the next cycle, outside reset
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("token scanner check failed");

`endif

// ===== design/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsc_pkg
// Types, character codes and helpers for the token scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

  localparam int unsigned CountWidthDefault = 8;
  localparam int unsigned OutCountWidth     = 8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SKIP = 2'd1,
    PH_TERM = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_NONE   = 2'd1,
    ST_UNTERM = 2'd2
  } status_e;

  function automatic logic is_term(input logic [7:0] c);
    is_term = (c == CH_SPACE) || (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_COMMA);
  endfunction

endpackage

`default_nettype wire

// ===== design/tsc_intf.sv =====
// ----------------------------------------------------------------------------
// tsc_intf
// Valid/ready channels for character beats and scan result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tsc_in_if
  import tsc_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;

  modport source (output valid, ch, first, input ready);
  modport sink   (input valid, ch, first, output ready);
endinterface

interface tsc_out_if
  import tsc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  status_e                  status;
  logic [OutCountWidth-1:0] skip_count;
  logic [OutCountWidth-1:0] token_length;

  modport source (output valid, status, skip_count, token_length, input ready);
  modport sink   (input valid, status, skip_count, token_length, output ready);
endinterface

`default_nettype wire

// ===== design/token_scanner_core.sv =====
// ----------------------------------------------------------------------------
// token_scanner_core
// Streaming token finder: one character beat per cycle unless a held result
// beat stalls input; one result beat per scan, once the token is decided.
// ----------------------------------------------------------------------------
// A character beat is taken every cycle while the result register is empty
// or being drained; a scan starts at a beat with first set. The scan state
// (phase, quote flag, space and length counters) updates in the cycle the
// beat is taken, and the result of the deciding character appears in the
// result register on the next cycle. The sustained rate is one character per
// cycle unless a held result stalls input, set by the single state update.
// Counters saturate at 2**COUNT_WIDTH - 1 and report their low 8 bits.
`timescale 1ns / 1ps
`default_nettype none

`include "token_scanner_core_macros.svh"

module token_scanner_core
  import tsc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  tsc_in_if.sink       in_i,
  tsc_out_if.source    out_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  phase_e                   phase_q, phase_d;
  logic                     quote_q, quote_d;
  logic [COUNT_WIDTH-1:0]   spaces_q, spaces_d;
  logic [COUNT_WIDTH-1:0]   len_q, len_d;

  logic                     out_valid_q;
  status_e                  status_q, status_d;
  logic [OutCountWidth-1:0] skip_q, skip_d;
  logic [OutCountWidth-1:0] tlen_q, tlen_d;

  logic                     in_ready;
  logic                     in_acc;
  logic                     res_emit;
  logic                     res_load;

  phase_e                   ph;
  logic                     qt;
  logic [COUNT_WIDTH-1:0]   sp;
  logic [COUNT_WIDTH-1:0]   ln;
  logic [COUNT_WIDTH-1:0]   emit_len;
  logic [COUNT_WIDTH+OutCountWidth-1:0] sp_ext;
  logic [COUNT_WIDTH+OutCountWidth-1:0] ln_ext;

  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;
  assign res_load   = in_acc && res_emit;

  always_comb begin
    ph = in_i.first ? PH_SKIP : phase_q;
    qt = in_i.first ? 1'b0 : quote_q;
    sp = in_i.first ? '0 : spaces_q;
    ln = in_i.first ? '0 : len_q;

    phase_d  = ph;
    quote_d  = qt;
    spaces_d = sp;
    len_d    = ln;
    res_emit = 1'b0;
    status_d = ST_FOUND;
    emit_len = '0;

    unique case (ph)
      PH_SKIP: begin
        if (in_i.ch == CH_SPACE) begin
          spaces_d = (sp == CountMax) ? sp : sp + 1'b1;
        end else if (in_i.ch == CH_NUL) begin
          res_emit = 1'b1;
          status_d = ST_NONE;
        end else if (is_term(in_i.ch)) begin
          phase_d = PH_TERM;
        end else begin
          len_d   = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
          quote_d = (in_i.ch == CH_QUOTE);
          phase_d = PH_BODY;
        end
      end
      PH_TERM: begin
        res_emit = 1'b1;
        emit_len = (is_term(in_i.ch) && in_i.ch != CH_SPACE) ? COUNT_WIDTH'(2) :
                                                               COUNT_WIDTH'(1);
      end
      PH_BODY: begin
        if (in_i.ch == CH_NUL) begin
          res_emit = 1'b1;
          status_d = qt ? ST_UNTERM : ST_FOUND;
          emit_len = ln;
        end else if (is_term(in_i.ch) && !qt) begin
          res_emit = 1'b1;
          emit_len = ln;
        end else begin
          if (in_i.ch == CH_QUOTE) begin
            quote_d = !qt;
          end
          len_d = (ln == CountMax) ? ln : ln + 1'b1;
        end
      end
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (res_emit) begin
      phase_d = PH_IDLE;
    end

    sp_ext = {{OutCountWidth{1'b0}}, sp};
    ln_ext = {{OutCountWidth{1'b0}}, emit_len};
    skip_d = sp_ext[OutCountWidth-1:0];
    tlen_d = ln_ext[OutCountWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      quote_q  <= 1'b0;
      spaces_q <= '0;
      len_q    <= '0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      quote_q  <= quote_d;
      spaces_q <= spaces_d;
      len_q    <= len_d;
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready) begin
      out_valid_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q <= status_d;
      skip_q   <= skip_d;
      tlen_q   <= tlen_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.skip_count   = skip_q;
  assign out_o.token_length = tlen_q;

  `TSC_ASSERT_NEXT(a_load_shows_beat, clk_i, rst_ni, res_load, out_valid_q)
  `TSC_ASSERT_NEXT(a_emit_goes_idle, clk_i, rst_ni, res_load, phase_q == PH_IDLE)
  `TSC_ASSERT_NEXT(a_idle_stays_idle, clk_i, rst_ni,
                   in_acc && !in_i.first && phase_q == PH_IDLE,
                   phase_q == PH_IDLE && !out_valid_q)
  `TSC_ASSERT_NOW(a_stall_blocks_input, clk_i, rst_ni,
                  out_valid_q && !out_o.ready, !in_i.ready)

endmodule

`default_nettype wire
